/* rtl/lirs_pkg.sv */
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared constants and types for the LIRS replacement policy core.
// ----------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

	localparam int CACHE_ENTRIES_DEF = 16;
	localparam int STACK_DEPTH_DEF   = 32;
	localparam int KEY_BITS_DEF      = 32;

	localparam int ACCESS_KEY_W = 32;
	localparam int EVICT_KEY_W  = 32;
	localparam int LIMIT_W      = 4;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_LIR_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIR_LIMIT = 1'd1;

	localparam logic [LIMIT_W-1:0] LIR_LIMIT_RST = 4'd15;
	localparam logic [LIMIT_W-1:0] HIR_LIMIT_RST = 4'd1;

	typedef struct packed {
		logic [LIMIT_W-1:0] lir_limit;
		logic [LIMIT_W-1:0] hir_limit;
	} lirs_cfg_t;

	typedef struct packed {
		logic                   resident_hit;
		logic                   evict_valid;
		logic [EVICT_KEY_W-1:0] evicted_key;
	} lirs_res_t;

endpackage

`default_nettype wire

/* rtl/lirs_if.sv */
// ----------------------------------------------------------------------------
// lirs_access_if / lirs_result_if
// Valid/ready channels for access keys and per-access results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lirs_access_if;
	logic                             valid;
	logic                             ready;
	logic [lirs_pkg::ACCESS_KEY_W-1:0] access_key;

	modport source (output valid, output access_key, input ready);
	modport sink   (input valid, input access_key, output ready);
endinterface

interface lirs_result_if;
	logic                            valid;
	logic                            ready;
	logic                            resident_hit;
	logic                            evict_valid;
	logic [lirs_pkg::EVICT_KEY_W-1:0] evicted_key;

	modport source (output valid, output resident_hit, output evict_valid,
		output evicted_key, input ready);
	modport sink   (input valid, input resident_hit, input evict_valid,
		input evicted_key, output ready);
endinterface

`default_nettype wire

/* rtl/lirs_ram.sv */
// ----------------------------------------------------------------------------
// lirs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_ram #(
	parameter int W = 34,
	parameter int D = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/lirs_seq.sv */
// ----------------------------------------------------------------------------
// lirs_seq
// Sequencer: searches the recency stack and HIR queue, then runs the
// evict / clear / remove / push / demote / prune / queue steps as memory shift loops.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_seq #(
	parameter int CACHE_ENTRIES = lirs_pkg::CACHE_ENTRIES_DEF,
	parameter int STACK_DEPTH   = lirs_pkg::STACK_DEPTH_DEF,
	parameter int KEY_BITS      = lirs_pkg::KEY_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lirs_pkg::lirs_cfg_t         cfg,
	input  wire logic                        in_valid,
	input  wire logic [KEY_BITS-1:0]         in_key,
	output logic                             in_ready,
	input  wire logic                        out_free,
	output logic                             done,
	output lirs_pkg::lirs_res_t              res
);
	import lirs_pkg::*;

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int QAW = $clog2(CACHE_ENTRIES);
	localparam int QCW = $clog2(CACHE_ENTRIES + 1);
	localparam int IW  = (SCW > QCW) ? SCW : QCW;
	localparam int CW  = (SCW > LIMIT_W) ? SCW : LIMIT_W;
	localparam int HW  = (QCW > LIMIT_W) ? QCW : LIMIT_W;
	localparam int SW  = KEY_BITS + 2;
	localparam int F_RES = KEY_BITS;
	localparam int F_LIR = KEY_BITS + 1;

	// step list, run in this order
	localparam int OP_EV = 0;
	localparam int OP_QR = 1;
	localparam int OP_CL = 2;
	localparam int OP_RM = 3;
	localparam int OP_PS = 4;
	localparam int OP_DM = 5;
	localparam int OP_PR = 6;
	localparam int OP_QP = 7;
	localparam int NOPS  = 8;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_SR_RD  = 5'd1;
	localparam logic [4:0] S_SR_CMP = 5'd2;
	localparam logic [4:0] S_DEC    = 5'd3;
	localparam logic [4:0] S_NEXT   = 5'd4;
	localparam logic [4:0] S_EV_RD  = 5'd5;
	localparam logic [4:0] S_EV_WT  = 5'd6;
	localparam logic [4:0] S_QR_RD  = 5'd7;
	localparam logic [4:0] S_QR_WR  = 5'd8;
	localparam logic [4:0] S_CL_RD  = 5'd9;
	localparam logic [4:0] S_CL_CMP = 5'd10;
	localparam logic [4:0] S_RM_RD  = 5'd11;
	localparam logic [4:0] S_RM_WR  = 5'd12;
	localparam logic [4:0] S_PS_CHK = 5'd13;
	localparam logic [4:0] S_VS_RD  = 5'd14;
	localparam logic [4:0] S_VS_CMP = 5'd15;
	localparam logic [4:0] S_PS_RD  = 5'd16;
	localparam logic [4:0] S_PS_WR  = 5'd17;
	localparam logic [4:0] S_DM_RD  = 5'd18;
	localparam logic [4:0] S_DM_CMP = 5'd19;
	localparam logic [4:0] S_QP     = 5'd20;
	localparam logic [4:0] S_PR_RD  = 5'd21;
	localparam logic [4:0] S_PR_CMP = 5'd22;
	localparam logic [4:0] S_DONE   = 5'd23;

	logic [4:0]          state_q, ret_q;
	logic [KEY_BITS-1:0] key_q, ek_q, qp_key_q;
	logic                s_found_q, s_lir_q, q_found_q;
	logic [SCW-1:0]      s_idx_q;
	logic [QCW-1:0]      q_idx_q;
	logic [NOPS-1:0]     ops_q;
	logic                push_lir_q, hit_q, ev_q, rem_lir_q, pass_q;
	logic [SCW-1:0]      sj_q, scount_q, lcount_q;
	logic [QCW-1:0]      qj_q, qcount_q;
	logic [IW-1:0]       si_q;

	logic           s_we, q_we;
	logic [SAW-1:0] s_waddr, s_raddr;
	logic [QAW-1:0] q_waddr, q_raddr;
	logic [SW-1:0]  s_wdata, s_rdata;
	logic [KEY_BITS-1:0] q_wdata, q_rdata;

	lirs_ram #(.W(SW), .D(STACK_DEPTH)) u_stk (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	lirs_ram #(.W(KEY_BITS), .D(CACHE_ENTRIES)) u_hq (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	logic [SCW-1:0] sj_inc, sj_dec, sc_dec;
	logic [QCW-1:0] qj_inc;
	logic           s_lir_rd, s_res_rd, s_match, q_match;
	logic [CW-1:0]  lir_cap;
	logic           lir_warm, q_full, do_evict;
	logic           case_a, case_b, case_c, case_d, case_e;
	logic           si_in_s, si_in_q;

	assign sj_inc   = sj_q + SCW'(1);
	assign sj_dec   = sj_q - SCW'(1);
	assign sc_dec   = scount_q - SCW'(1);
	assign qj_inc   = qj_q + QCW'(1);
	assign s_lir_rd = s_rdata[F_LIR];
	assign s_res_rd = s_rdata[F_RES];
	assign s_match  = (s_rdata[KEY_BITS-1:0] == key_q);
	assign q_match  = (q_rdata == key_q);
	assign si_in_s  = si_q < IW'(scount_q);
	assign si_in_q  = si_q < IW'(qcount_q);

	assign lir_cap  = (CW'(cfg.lir_limit) < CW'(STACK_DEPTH - 1)) ?
		CW'(cfg.lir_limit) : CW'(STACK_DEPTH - 1);
	assign lir_warm = CW'(lcount_q) < lir_cap;
	assign q_full   = (HW'(qcount_q) >= HW'(cfg.hir_limit)) ||
		(qcount_q >= QCW'(CACHE_ENTRIES));

	assign case_a   = s_found_q && s_lir_q;
	assign case_b   = !case_a && q_found_q && s_found_q;
	assign case_c   = !case_a && q_found_q && !s_found_q;
	assign case_d   = !case_a && !q_found_q && lir_warm;
	assign case_e   = !case_a && !q_found_q && !lir_warm;
	assign do_evict = case_e && q_full && (qcount_q != '0);

	assign in_ready = (state_q == S_IDLE);
	assign done     = (state_q == S_DONE) && out_free;

	always_comb begin
		res.resident_hit = hit_q;
		res.evict_valid  = ev_q;
		res.evicted_key  = ev_q ? EVICT_KEY_W'(ek_q) : '0;
	end

	always_comb begin
		s_we    = 1'b0;
		s_waddr = sj_q[SAW-1:0];
		s_wdata = s_rdata;
		s_raddr = sj_q[SAW-1:0];
		q_we    = 1'b0;
		q_waddr = qj_q[QAW-1:0];
		q_wdata = q_rdata;
		q_raddr = qj_q[QAW-1:0];
		case (state_q)
			S_SR_RD: begin
				s_raddr = si_q[SAW-1:0];
				q_raddr = si_q[QAW-1:0];
			end
			S_EV_RD: q_raddr = '0;
			S_QR_RD: q_raddr = qj_inc[QAW-1:0];
			S_QR_WR: q_we = 1'b1;
			S_CL_CMP: begin
				s_we    = (s_rdata[KEY_BITS-1:0] == ek_q);
				s_wdata = {s_lir_rd, 1'b0, s_rdata[KEY_BITS-1:0]};
			end
			S_RM_RD: s_raddr = sj_inc[SAW-1:0];
			S_RM_WR: s_we = 1'b1;
			S_PS_RD: begin
				s_raddr = sj_dec[SAW-1:0];
				s_we    = (sj_q == '0);
				s_wdata = {push_lir_q, 1'b1, key_q};
			end
			S_PS_WR: s_we = 1'b1;
			S_QP: begin
				q_we    = qcount_q < QCW'(CACHE_ENTRIES);
				q_waddr = qcount_q[QAW-1:0];
				q_wdata = qp_key_q;
			end
			S_PR_RD: s_raddr = sc_dec[SAW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_NEXT;
			ops_q    <= '0;
			scount_q <= '0;
			lcount_q <= '0;
			qcount_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q     <= in_key;
						ek_q      <= '0;
						s_found_q <= 1'b0;
						q_found_q <= 1'b0;
						si_q      <= '0;
						state_q   <= S_SR_RD;
					end
				end
				S_SR_RD: begin
					if (!si_in_s && !si_in_q) begin
						state_q <= S_DEC;
					end else begin
						state_q <= S_SR_CMP;
					end
				end
				S_SR_CMP: begin
					if (si_in_s && !s_found_q && s_match) begin
						s_found_q <= 1'b1;
						s_idx_q   <= si_q[SCW-1:0];
						s_lir_q   <= s_lir_rd;
					end
					if (si_in_q && !q_found_q && q_match) begin
						q_found_q <= 1'b1;
						q_idx_q   <= si_q[QCW-1:0];
					end
					si_q    <= si_q + IW'(1);
					state_q <= S_SR_RD;
				end
				S_DEC: begin
					hit_q      <= case_a || case_b || case_c;
					ev_q       <= do_evict;
					push_lir_q <= !(case_c || (case_e && !s_found_q));
					ops_q[OP_EV] <= do_evict;
					ops_q[OP_QR] <= case_b || case_c || do_evict;
					ops_q[OP_CL] <= do_evict;
					ops_q[OP_RM] <= case_a || case_b || (s_found_q && (case_d || case_e));
					ops_q[OP_PS] <= 1'b1;
					ops_q[OP_DM] <= (case_b && !lir_warm) || (case_e && s_found_q);
					ops_q[OP_PR] <= case_a || case_b || case_d || (case_e && s_found_q);
					ops_q[OP_QP] <= case_c || (case_e && !s_found_q);
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					ret_q <= S_NEXT;
					if (ops_q[OP_EV]) begin
						ops_q[OP_EV] <= 1'b0;
						state_q      <= S_EV_RD;
					end else if (ops_q[OP_QR]) begin
						ops_q[OP_QR] <= 1'b0;
						qj_q         <= ev_q ? '0 : q_idx_q;
						state_q      <= S_QR_RD;
					end else if (ops_q[OP_CL]) begin
						ops_q[OP_CL] <= 1'b0;
						sj_q         <= '0;
						state_q      <= S_CL_RD;
					end else if (ops_q[OP_RM]) begin
						ops_q[OP_RM] <= 1'b0;
						sj_q         <= s_idx_q;
						rem_lir_q    <= s_lir_q;
						state_q      <= S_RM_RD;
					end else if (ops_q[OP_PS]) begin
						ops_q[OP_PS] <= 1'b0;
						state_q      <= S_PS_CHK;
					end else if (ops_q[OP_DM]) begin
						ops_q[OP_DM] <= 1'b0;
						sj_q         <= sc_dec;
						state_q      <= S_DM_RD;
					end else if (ops_q[OP_PR]) begin
						ops_q[OP_PR] <= 1'b0;
						state_q      <= S_PR_RD;
					end else if (ops_q[OP_QP]) begin
						ops_q[OP_QP] <= 1'b0;
						qp_key_q     <= key_q;
						state_q      <= S_QP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EV_RD: state_q <= S_EV_WT;
				S_EV_WT: begin
					ek_q    <= q_rdata;
					state_q <= S_NEXT;
				end
				S_QR_RD: begin
					if (qj_inc >= qcount_q) begin
						qcount_q <= qcount_q - QCW'(1);
						state_q  <= S_NEXT;
					end else begin
						state_q <= S_QR_WR;
					end
				end
				S_QR_WR: begin
					qj_q    <= qj_inc;
					state_q <= S_QR_RD;
				end
				S_CL_RD: begin
					state_q <= (sj_q >= scount_q) ? S_NEXT : S_CL_CMP;
				end
				S_CL_CMP: begin
					if (s_rdata[KEY_BITS-1:0] == ek_q) begin
						state_q <= S_NEXT;
					end else begin
						sj_q    <= sj_inc;
						state_q <= S_CL_RD;
					end
				end
				S_RM_RD: begin
					if (sj_inc >= scount_q) begin
						scount_q <= sc_dec;
						if (rem_lir_q) begin
							lcount_q <= lcount_q - SCW'(1);
						end
						state_q <= ret_q;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					sj_q    <= sj_inc;
					state_q <= S_RM_RD;
				end
				S_PS_CHK: begin
					if (scount_q >= SCW'(STACK_DEPTH)) begin
						pass_q  <= 1'b0;
						sj_q    <= sc_dec;
						state_q <= S_VS_RD;
					end else begin
						sj_q    <= scount_q;
						state_q <= S_PS_RD;
					end
				end
				S_VS_RD: state_q <= S_VS_CMP;
				S_VS_CMP: begin
					// full stack: drop oldest non-resident, else oldest HIR, else bottom
					if ((!pass_q && !s_res_rd) || (pass_q && !s_lir_rd)) begin
						rem_lir_q <= s_lir_rd;
						ret_q     <= S_PS_CHK;
						state_q   <= S_RM_RD;
					end else if (sj_q == '0) begin
						sj_q <= sc_dec;
						if (!pass_q) begin
							pass_q  <= 1'b1;
							state_q <= S_VS_RD;
						end else begin
							rem_lir_q <= 1'b1;
							ret_q     <= S_PS_CHK;
							state_q   <= S_RM_RD;
						end
					end else begin
						sj_q    <= sj_dec;
						state_q <= S_VS_RD;
					end
				end
				S_PS_RD: begin
					if (sj_q == '0) begin
						scount_q <= scount_q + SCW'(1);
						if (push_lir_q) begin
							lcount_q <= lcount_q + SCW'(1);
						end
						state_q <= S_NEXT;
					end else begin
						state_q <= S_PS_WR;
					end
				end
				S_PS_WR: begin
					sj_q    <= sj_dec;
					state_q <= S_PS_RD;
				end
				S_DM_RD: begin
					// the top entry is never demoted
					state_q <= (sj_q == '0) ? S_NEXT : S_DM_CMP;
				end
				S_DM_CMP: begin
					if (s_lir_rd) begin
						qp_key_q  <= s_rdata[KEY_BITS-1:0];
						rem_lir_q <= 1'b1;
						ret_q     <= S_QP;
						state_q   <= S_RM_RD;
					end else begin
						sj_q    <= sj_dec;
						state_q <= S_DM_RD;
					end
				end
				S_QP: begin
					if (qcount_q < QCW'(CACHE_ENTRIES)) begin
						qcount_q <= qcount_q + QCW'(1);
					end
					state_q <= S_NEXT;
				end
				S_PR_RD: begin
					state_q <= (scount_q == '0) ? S_NEXT : S_PR_CMP;
				end
				S_PR_CMP: begin
					if (!s_lir_rd) begin
						sj_q      <= sc_dec;
						rem_lir_q <= 1'b0;
						ret_q     <= S_PR_RD;
						state_q   <= S_RM_RD;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/lirs_replacement_policy_core.sv */
// Operation: a search of the stack and queue over the larger of their fills, then a decode,
//   then each evict/clear/remove/push/demote/prune/queue step scans or shifts its entries.
// One access at a time; the next is taken only once the result has been registered.
// Reset: counts cleared (empty stack and queue), lir_limit=15, hir_limit=1;
//   RAM contents are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// lirs_replacement_policy_core
// LIRS replacement policy for a small fully associative cache.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_replacement_policy_core #(
	parameter int CACHE_ENTRIES = lirs_pkg::CACHE_ENTRIES_DEF,
	parameter int STACK_DEPTH   = lirs_pkg::STACK_DEPTH_DEF,
	parameter int KEY_BITS      = lirs_pkg::KEY_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	lirs_access_if.sink                         acc,
	lirs_result_if.source                       res,
	input  wire logic                           cfg_we,
	input  wire logic [lirs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [lirs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lirs_pkg::*;

	lirs_cfg_t cfg_q;
	lirs_res_t res_q, seq_res;
	logic      res_valid_q, out_free, seq_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lir_limit <= LIR_LIMIT_RST;
			cfg_q.hir_limit <= HIR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LIR_LIMIT: cfg_q.lir_limit <= cfg_wdata[LIMIT_W-1:0];
				REG_HIR_LIMIT: cfg_q.hir_limit <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !res_valid_q || res.ready;

	lirs_seq #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.STACK_DEPTH(STACK_DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(acc.valid),
		.in_key(KEY_BITS'(acc.access_key)),
		.in_ready(acc.ready),
		.out_free(out_free),
		.done(seq_done),
		.res(seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (seq_done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			res_q <= seq_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.resident_hit = res_q.resident_hit;
	assign res.evict_valid  = res_q.evict_valid;
	assign res.evicted_key  = res_q.evicted_key;

endmodule

`default_nettype wire

/* rtl/lirs_chk.sv */
// ----------------------------------------------------------------------------
// lirs_chk
// Port-level checks for the LIRS policy core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        resident_hit,
	input wire logic        evict_valid,
	input wire logic [31:0] evicted_key
);

	// an eviction only happens on a miss
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evict_valid |-> !resident_hit)
		else $error("eviction reported on a hit");

	a_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evict_valid |-> evicted_key == 32'd0)
		else $error("evicted key nonzero without eviction");

	// one access in flight: input closes right after a transaction
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second access taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(evicted_key))
		else $error("stalled result dropped or changed");

endmodule

bind lirs_replacement_policy_core lirs_chk u_lirs_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(acc.valid),
	.in_ready(acc.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.resident_hit(res.resident_hit),
	.evict_valid(res.evict_valid),
	.evicted_key(res.evicted_key)
);

`default_nettype wire
